// ----- hw/rtl/dbfs_pkg.sv -----
// Shared types, codes and constants for the double-buffered pixel frame store.
// Used by the controller, the datapath, the RAM and the top level.
package dbfs_pkg;

    localparam int DEF_MAX_PIXELS      = 1024;
    localparam int DEF_MAX_PIXEL_BYTES = 4;
    localparam int DEF_RAM_WIDTH       = 8;
    localparam int DEF_RAM_DEPTH       = 2 * DEF_MAX_PIXELS * DEF_MAX_PIXEL_BYTES;

    localparam int PCOUNT_W = 11;
    localparam int PBYTES_W = 3;
    localparam int FSZ_W    = PCOUNT_W + PBYTES_W;
    localparam int CFG_W    = PCOUNT_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [PCOUNT_W-1:0] PIXEL_COUNT_RESET = 11'd1024;
    localparam logic [PBYTES_W-1:0] PIXEL_BYTES_RESET = 3'd3;
    localparam logic [PBYTES_W-1:0] RGB_BYTES         = 3'd3;
    localparam logic [15:0]         FILL_TO_END       = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'd1;

    localparam logic [1:0] REPLY_ACCEPTED = 2'd0;
    localparam logic [1:0] REPLY_BUSY     = 2'd1;

    typedef enum logic [2:0] {
        KIND_SET_PIXEL  = 3'd0,
        KIND_FILL       = 3'd1,
        KIND_CLEAR      = 3'd2,
        KIND_WRITE_BYTE = 3'd3,
        KIND_COMMIT     = 3'd4,
        KIND_POLL       = 3'd5,
        KIND_MARK_DIRTY = 3'd6,
        KIND_READ_FRONT = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_BUSY    = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_PAINT,
        S_ZERO,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [9:0]  pixel_index;
        logic [15:0] fill_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] byte_offset;
        logic [7:0]  byte_value;
        logic [12:0] region_end;
        logic        backend_busy;
        logic [1:0]  backend_reply;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        submit_frame;
        logic        front_bank;
        logic        dirty_flag;
        logic        pending_flag;
        logic [7:0]  read_data;
    } t_out_item;

    typedef struct packed {
        logic init;
        logic load;
        logic decode;
        logic paint;
        logic zero;
        logic read;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  arg_err;
        logic  frame_empty;
        logic  paint_last;
        logic  zero_last;
        logic  init_last;
        logic  out_free;
    } t_stat;

endpackage

// ----- hw/rtl/dbfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on dbfs_pkg for default sizes only.
module dbfs_ram
    import dbfs_pkg::*;
#(
    parameter int WIDTH = DEF_RAM_WIDTH,
    parameter int DEPTH = DEF_RAM_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dbfs_ctrl.sv -----
// Sequencing state machine for the frame store: clearing pass, decode,
// byte walks, front read and result hand-off. Depends on dbfs_pkg.
module dbfs_ctrl
    import dbfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_stat.kind)
                    KIND_SET_PIXEL, KIND_FILL: begin
                        n_state = i_stat.arg_err ? S_FINISH : S_PAINT;
                    end
                    KIND_CLEAR: begin
                        n_state = i_stat.frame_empty ? S_FINISH : S_ZERO;
                    end
                    KIND_READ_FRONT: begin
                        n_state = i_stat.arg_err ? S_FINISH : S_READ;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_PAINT: begin
                o_cmd.paint = 1'b1;
                if (i_stat.paint_last) begin
                    n_state = S_FINISH;
                end
            end
            S_ZERO: begin
                o_cmd.zero = 1'b1;
                if (i_stat.zero_last) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded next cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_stat.out_free) |=> (r_state == S_FINISH))
        else $error("result dropped while output register full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_in_ready)
        else $error("item accepted during clearing pass");

endmodule

// ----- hw/rtl/dbfs_datapath.sv -----
// Datapath of the frame store: configuration, flags, item and walk registers,
// bank RAM and result register. Depends on dbfs_pkg and dbfs_ram.
module dbfs_datapath
    import dbfs_pkg::*;
#(
    parameter int MAX_PIXELS      = DEF_MAX_PIXELS,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_item,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out_item            o_out_item,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    localparam int BANK_BYTES = MAX_PIXELS * MAX_PIXEL_BYTES;
    localparam int DEPTH      = 2 * BANK_BYTES;
    localparam int AW         = $clog2(DEPTH);
    localparam int BAW        = $clog2(BANK_BYTES);
    localparam int WW         = ((BAW > FSZ_W) ? BAW : FSZ_W) + 1;
    localparam int KW         = $clog2(MAX_PIXEL_BYTES);

    logic [PCOUNT_W-1:0] r_pcount;
    logic [PBYTES_W-1:0] r_pbytes;
    logic                r_front;
    logic                r_dirty;
    logic                r_pending;
    t_in_item            r_item;
    logic                r_err;
    logic [WW-1:0]       r_addr;
    logic [KW-1:0]       r_k;
    logic [PCOUNT_W-1:0] r_pix;
    logic [PCOUNT_W-1:0] r_pix_end;
    logic [FSZ_W-1:0]    r_end;
    logic [AW-1:0]       r_init;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [PCOUNT_W-1:0] np;
    logic [PBYTES_W-1:0] bpp;
    logic [FSZ_W-1:0]    fsz;
    logic [15:0]         run;
    logic [16:0]         pix_end;
    logic [WW-1:0]       base;
    logic                arg_err;
    logic                n_front;
    logic                n_dirty;
    logic                n_pending;
    logic                do_submit;
    t_out_item           fin;
    logic [7:0]          paint_data;
    logic                ram_we;
    logic                use_init;
    logic [WW-1:0]       wbyte;
    logic [WW-1:0]       rbyte;
    logic [7:0]          ram_wdata;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;

    // Effective geometry after clamping
    always_comb begin
        np  = ({6'd0, r_pcount} > 17'(MAX_PIXELS)) ? PCOUNT_W'(MAX_PIXELS) : r_pcount;
        bpp = ({1'b0, r_pbytes} > 4'(MAX_PIXEL_BYTES)) ? PBYTES_W'(MAX_PIXEL_BYTES)
                                                        : r_pbytes;
        fsz = FSZ_W'(np) * FSZ_W'(bpp);
    end

    // Argument checks on the held item
    always_comb begin
        if (r_item.kind == KIND_FILL) begin
            run = (r_item.fill_count == FILL_TO_END)
                ? 16'(np - {1'b0, r_item.pixel_index}) : r_item.fill_count;
        end else begin
            run = 16'd1;
        end
        pix_end = 17'(r_item.pixel_index) + 17'(run);
        base    = WW'(r_item.pixel_index) * WW'(bpp);
        case (r_item.kind)
            KIND_SET_PIXEL, KIND_FILL: begin
                arg_err = (bpp < RGB_BYTES) || ({1'b0, r_item.pixel_index} >= np)
                       || (run == 16'd0) || (pix_end > 17'(np));
            end
            KIND_WRITE_BYTE: begin
                arg_err = (r_item.region_end <= 13'(r_item.byte_offset))
                       || (14'(r_item.region_end) > fsz);
            end
            KIND_READ_FRONT: begin
                arg_err = (14'(r_item.byte_offset) >= fsz);
            end
            default: begin
                arg_err = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_stat.kind        = r_item.kind;
        o_stat.arg_err     = arg_err;
        o_stat.frame_empty = (fsz == '0);
        o_stat.paint_last  = (r_k == KW'(bpp - 3'd1)) && (r_pix + 11'd1 == r_pix_end);
        o_stat.zero_last   = (r_addr + WW'(1) == WW'(r_end));
        o_stat.init_last   = (r_init == AW'(DEPTH - 1));
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= PIXEL_COUNT_RESET;
            r_pbytes <= PIXEL_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_COUNT: r_pcount <= i_cfg_data[PCOUNT_W-1:0];
                CFG_PIXEL_BYTES: r_pbytes <= i_cfg_data[PBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.decode) begin
            r_err     <= arg_err;
            r_addr    <= (r_item.kind == KIND_CLEAR) ? '0 : base;
            r_k       <= '0;
            r_pix     <= PCOUNT_W'(r_item.pixel_index);
            r_pix_end <= pix_end[PCOUNT_W-1:0];
            r_end     <= fsz;
        end else if (i_cmd.paint) begin
            r_addr <= r_addr + WW'(1);
            if (r_k == KW'(bpp - 3'd1)) begin
                r_k   <= '0;
                r_pix <= r_pix + 11'd1;
            end else begin
                r_k <= r_k + KW'(1);
            end
        end else if (i_cmd.zero) begin
            r_addr <= r_addr + WW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_cmd.init) begin
            r_init <= r_init + AW'(1);
        end
    end

    // Flag updates and result for the held item
    always_comb begin
        n_front   = r_front;
        n_dirty   = r_dirty;
        n_pending = r_pending;
        do_submit = 1'b0;
        fin       = '0;
        fin.status = r_err ? ST_BAD_ARG : ST_OK;
        case (r_item.kind)
            KIND_SET_PIXEL, KIND_FILL, KIND_WRITE_BYTE: begin
                if (!r_err) begin
                    n_dirty = 1'b1;
                end
            end
            KIND_CLEAR, KIND_MARK_DIRTY: begin
                n_dirty = 1'b1;
            end
            KIND_COMMIT: begin
                if (r_dirty) begin
                    n_front = ~r_front;
                    n_dirty = 1'b0;
                    if (r_item.backend_busy) begin
                        n_pending = 1'b1;
                    end else begin
                        do_submit = 1'b1;
                    end
                end
            end
            KIND_POLL: begin
                do_submit = r_pending && !r_item.backend_busy;
            end
            KIND_READ_FRONT: begin
                if (!r_err) begin
                    fin.read_data = ram_rdata;
                end
            end
            default: ;
        endcase
        if (do_submit) begin
            fin.submit_frame = 1'b1;
            if (r_item.backend_reply == REPLY_ACCEPTED) begin
                n_pending  = 1'b0;
                fin.status = ST_OK;
            end else if (r_item.backend_reply == REPLY_BUSY) begin
                n_pending  = 1'b1;
                fin.status = ST_BUSY;
            end else begin
                fin.status = ST_ERROR;
            end
        end
        fin.front_bank   = n_front;
        fin.dirty_flag   = n_dirty;
        fin.pending_flag = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= 1'b0;
            r_dirty   <= 1'b1;
            r_pending <= 1'b0;
        end else if (i_cmd.finish) begin
            r_front   <= n_front;
            r_dirty   <= n_dirty;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // RAM access
    always_comb begin
        case (r_k)
            KW'(0):  paint_data = r_item.red;
            KW'(1):  paint_data = r_item.green;
            KW'(2):  paint_data = r_item.blue;
            default: paint_data = 8'd0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        use_init  = 1'b0;
        wbyte     = r_addr;
        ram_wdata = 8'd0;
        if (i_cmd.init) begin
            ram_we   = 1'b1;
            use_init = 1'b1;
        end else if (i_cmd.paint) begin
            ram_we    = 1'b1;
            ram_wdata = paint_data;
        end else if (i_cmd.zero) begin
            ram_we = 1'b1;
        end else if (i_cmd.finish && r_item.kind == KIND_WRITE_BYTE && !r_err) begin
            ram_we    = 1'b1;
            wbyte     = WW'(r_item.byte_offset);
            ram_wdata = r_item.byte_value;
        end
    end

    assign rbyte     = WW'(r_item.byte_offset);
    assign ram_waddr = use_init ? r_init
                     : (!r_front ? AW'(BANK_BYTES) + AW'(wbyte[BAW-1:0])
                                 : AW'(wbyte[BAW-1:0]));
    assign ram_raddr = r_front ? AW'(BANK_BYTES) + AW'(rbyte[BAW-1:0])
                               : AW'(rbyte[BAW-1:0]);

    dbfs_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.read),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.paint |-> (r_addr < WW'(fsz)))
        else $error("pixel write beyond frame");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.zero |-> (r_addr < WW'(r_end)))
        else $error("clear walk beyond frame");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front != $past(r_front)) |-> ($past(i_cmd.finish)
                                         && $past(r_item.kind) == KIND_COMMIT))
        else $error("banks swapped outside a commit");

endmodule

// ----- hw/rtl/double_buffered_pixel_frame_store_top.sv -----
// Top level of the double-buffered pixel frame store.
// Depends on dbfs_pkg, dbfs_ctrl, dbfs_datapath and dbfs_ram.
//
//   port group     direction  handshake               payload
//   input items    in         i_in_valid/o_in_ready   i_in_item (t_in_item)
//   result items   out        o_out_valid/i_out_ready o_out_item (t_out_item)
//   configuration  in         i_cfg_we                i_cfg_index, i_cfg_data
//
// Flag items, write byte and a rejected item pass through decode and finish only;
// read front adds a RAM read. Set pixel and fill write pixel_bytes bytes per pixel,
// and clear writes each frame byte: one RAM write port, one byte a cycle.
// After reset a clearing pass zeroes both banks before the first item is taken.
// A finished result waits while the output register is full; a new item
// is taken while an earlier result still waits.
module double_buffered_pixel_frame_store_top
    import dbfs_pkg::*;
#(
    parameter int MAX_PIXELS      = DEF_MAX_PIXELS,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    t_cmd  cmd;
    t_stat stat;

    dbfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    dbfs_datapath #(
        .MAX_PIXELS     (MAX_PIXELS),
        .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

// ----- test/double_buffered_pixel_frame_store_top_tb.sv -----
// Self-checking testbench for double_buffered_pixel_frame_store_top: directed and random items
// under random backpressure, checked against a scoreboard that mirrors both banks and the flags.
// Depends on dbfs_pkg and the double_buffered_pixel_frame_store_top RTL.
module double_buffered_pixel_frame_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbfs_pkg::*;

    localparam int         BANK_BYTES      = DEF_MAX_PIXELS * DEF_MAX_PIXEL_BYTES;
    localparam int         IN_W            = $bits(t_in_item);
    localparam logic [1:0] REPLY_ERROR     = 2'd2;
    localparam logic [1:0] REPLY_UNDEFINED = 2'd3;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         LONG_HOLD       = 300;

    class frame_store_scoreboard;
        bit [7:0]    banks [2*BANK_BYTES];
        bit          front;
        bit          dirty;
        bit          pending;
        int unsigned pix_count;
        int unsigned pix_bytes;
        t_out_item   awaited_replies[$];
        int          errors;

        function new();
            foreach (banks[i]) banks[i] = 8'd0;
            front     = 1'b0;
            dirty     = 1'b1;
            pending   = 1'b0;
            pix_count = PIXEL_COUNT_RESET;
            pix_bytes = PIXEL_BYTES_RESET;
            errors    = 0;
        endfunction

        function int unsigned frame_pixels();
            return (pix_count > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : pix_count;
        endfunction

        function int unsigned pixel_width();
            return (pix_bytes > DEF_MAX_PIXEL_BYTES) ? DEF_MAX_PIXEL_BYTES : pix_bytes;
        endfunction

        function int unsigned frame_span();
            return frame_pixels() * pixel_width();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_PIXEL_COUNT) begin
                pix_count = data;
            end else if (idx == CFG_PIXEL_BYTES) begin
                pix_bytes = data[PBYTES_W-1:0];
            end
        endfunction

        function void paint(int unsigned base, int unsigned pix, int unsigned bpp, t_in_item it);
            int unsigned at;
            int unsigned k;
            at = base + pix * bpp;
            banks[at]     = it.red;
            banks[at + 1] = it.green;
            banks[at + 2] = it.blue;
            for (k = RGB_BYTES; k < bpp; k++) banks[at + k] = 8'd0;
        endfunction

        function t_status hand_over(logic [1:0] reply);
            if (reply == REPLY_ACCEPTED) begin
                pending = 1'b0;
                return ST_OK;
            end
            if (reply == REPLY_BUSY) begin
                pending = 1'b1;
                return ST_BUSY;
            end
            return ST_ERROR;
        endfunction

        function void take_item(t_in_item it);
            int unsigned np;
            int unsigned bpp;
            int unsigned fsz;
            int unsigned run;
            int unsigned back_base;
            int unsigned i;
            t_out_item   res;
            np        = frame_pixels();
            bpp       = pixel_width();
            fsz       = np * bpp;
            back_base = front ? 0 : BANK_BYTES;
            res       = '0;
            res.status = ST_OK;
            case (it.kind)
                KIND_SET_PIXEL: begin
                    if (bpp < RGB_BYTES || it.pixel_index >= np) begin
                        res.status = ST_BAD_ARG;
                    end else begin
                        paint(back_base, it.pixel_index, bpp, it);
                        dirty = 1'b1;
                    end
                end
                KIND_FILL: begin
                    if (bpp < RGB_BYTES || it.pixel_index >= np) begin
                        res.status = ST_BAD_ARG;
                    end else begin
                        run = (it.fill_count == FILL_TO_END) ? np - it.pixel_index : it.fill_count;
                        if (run == 0 || it.pixel_index + run > np) begin
                            res.status = ST_BAD_ARG;
                        end else begin
                            for (i = 0; i < run; i++) paint(back_base, it.pixel_index + i, bpp, it);
                            dirty = 1'b1;
                        end
                    end
                end
                KIND_CLEAR: begin
                    for (i = 0; i < fsz; i++) banks[back_base + i] = 8'd0;
                    dirty = 1'b1;
                end
                KIND_WRITE_BYTE: begin
                    if (it.region_end <= it.byte_offset || it.region_end > fsz) begin
                        res.status = ST_BAD_ARG;
                    end else begin
                        banks[back_base + it.byte_offset] = it.byte_value;
                        dirty = 1'b1;
                    end
                end
                KIND_COMMIT: begin
                    if (dirty) begin
                        front = ~front;
                        dirty = 1'b0;
                        if (it.backend_busy) begin
                            pending = 1'b1;
                        end else begin
                            res.status       = hand_over(it.backend_reply);
                            res.submit_frame = 1'b1;
                        end
                    end
                end
                KIND_POLL: begin
                    if (pending && !it.backend_busy) begin
                        res.status       = hand_over(it.backend_reply);
                        res.submit_frame = 1'b1;
                    end
                end
                KIND_MARK_DIRTY: begin
                    dirty = 1'b1;
                end
                default: begin
                    if (it.byte_offset >= fsz) begin
                        res.status = ST_BAD_ARG;
                    end else begin
                        res.read_data = banks[(front ? BANK_BYTES : 0) + it.byte_offset];
                    end
                end
            endcase
            res.front_bank   = front;
            res.dirty_flag   = dirty;
            res.pending_flag = pending;
            awaited_replies.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (awaited_replies.size() == 0) begin
                $display("%0t: result item with none awaited, expected nothing, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("submit_frame", want.submit_frame, got.submit_frame);
            compare_field("front_bank", want.front_bank, got.front_bank);
            compare_field("dirty_flag", want.dirty_flag, got.dirty_flag);
            compare_field("pending_flag", want.pending_flag, got.pending_flag);
            compare_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;

    frame_store_scoreboard board;
    int                    hold_left = 0;
    bit                    calm      = 1'b0;

    double_buffered_pixel_frame_store_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_reply(o_out_item);
    end

    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 12) stall_left = $urandom_range(1, 8);
            end
        end
    end

    initial begin
        #36ms;
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.take_item(it);
    endtask

    task automatic pause_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_op(t_kind kind, int unsigned idx, int unsigned cnt, int unsigned off,
                           int unsigned rend, bit busy, logic [1:0] reply);
        logic [IN_W-1:0] raw;
        t_in_item        it;
        raw              = IN_W'({$urandom, $urandom, $urandom});
        it               = raw;
        it.kind          = kind;
        it.pixel_index   = 10'(idx);
        it.fill_count    = 16'(cnt);
        it.byte_offset   = 12'(off);
        it.region_end    = 13'(rend);
        it.backend_busy  = busy;
        it.backend_reply = reply;
        send_item(it);
    endtask

    function automatic t_in_item random_item();
        logic [IN_W-1:0] raw;
        t_in_item        it;
        int unsigned     np;
        int unsigned     fsz;
        int unsigned     mode;
        int unsigned     pick;
        raw  = IN_W'({$urandom, $urandom, $urandom});
        it   = raw;
        np   = board.frame_pixels();
        fsz  = board.frame_span();
        mode = $urandom_range(0, 99);
        // keep the raw item as noise
        if (mode >= 95) return it;
        if (mode < 20)      it.kind = KIND_SET_PIXEL;
        else if (mode < 30) it.kind = KIND_FILL;
        else if (mode < 33) it.kind = KIND_CLEAR;
        else if (mode < 53) it.kind = KIND_WRITE_BYTE;
        else if (mode < 63) it.kind = KIND_COMMIT;
        else if (mode < 73) it.kind = KIND_POLL;
        else if (mode < 78) it.kind = KIND_MARK_DIRTY;
        else                it.kind = KIND_READ_FRONT;
        case (it.kind)
            KIND_SET_PIXEL, KIND_FILL: begin
                if (np > 0 && $urandom_range(0, 9) != 0) begin
                    it.pixel_index = 10'($urandom_range(0, np - 1));
                end
                pick = $urandom_range(0, 19);
                if (pick < 3)       it.fill_count = FILL_TO_END;
                else if (pick < 16) it.fill_count = 16'($urandom_range(1, 8));
            end
            KIND_WRITE_BYTE: begin
                if (fsz > 0 && $urandom_range(0, 9) != 0) begin
                    it.byte_offset = 12'($urandom_range(0, fsz - 1));
                    it.region_end  = 13'($urandom_range(it.byte_offset + 1, fsz));
                    if ($urandom_range(0, 9) == 0) it.region_end = 13'(fsz + 1);
                end
            end
            KIND_COMMIT, KIND_POLL: begin
                it.backend_busy = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) != 0) it.backend_reply = REPLY_ACCEPTED;
            end
            KIND_READ_FRONT: begin
                if (fsz > 0 && $urandom_range(0, 9) != 0) begin
                    it.byte_offset = 12'($urandom_range(0, fsz - 1));
                end
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    task automatic run_phase(int unsigned count_val, int unsigned bytes_val, int items,
                             bit quiet, int hold_at, int drain_at);
        logic [CFG_W-1:0] bytes_word;
        drain_results();
        bytes_word                 = CFG_W'($urandom);
        bytes_word[PBYTES_W-1:0]   = PBYTES_W'(bytes_val);
        write_register(CFG_PIXEL_COUNT, CFG_W'(count_val));
        write_register(CFG_PIXEL_BYTES, bytes_word);
        calm = quiet;
        for (int n = 0; n < items; n++) begin
            if (n == hold_at) hold_left = LONG_HOLD;
            if (n == drain_at) drain_results();
            if (!calm && $urandom_range(0, 99) < 15) pause_input($urandom_range(1, 8));
            send_item(random_item());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_PIXEL_COUNT;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        board       = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(KIND_READ_FRONT, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_SET_PIXEL, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_SET_PIXEL, 1023, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_FILL, 2, 3, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_FILL, 1020, FILL_TO_END, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_FILL, 1000, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_FILL, 1000, 25, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_WRITE_BYTE, 0, 0, 3071, 3072, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_WRITE_BYTE, 0, 0, 10, 10, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_WRITE_BYTE, 0, 0, 0, 3073, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_COMMIT, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_COMMIT, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_READ_FRONT, 0, 0, 3071, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_READ_FRONT, 0, 0, 3072, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_READ_FRONT, 0, 0, 4095, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_MARK_DIRTY, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_COMMIT, 0, 0, 0, 0, 1'b1, REPLY_ACCEPTED);
        send_op(KIND_POLL, 0, 0, 0, 0, 1'b1, REPLY_ACCEPTED);
        send_op(KIND_POLL, 0, 0, 0, 0, 1'b0, REPLY_BUSY);
        send_op(KIND_POLL, 0, 0, 0, 0, 1'b0, REPLY_UNDEFINED);
        send_op(KIND_POLL, 0, 0, 0, 0, 1'b0, REPLY_ERROR);
        send_op(KIND_POLL, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_CLEAR, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);
        send_op(KIND_COMMIT, 0, 0, 0, 0, 1'b0, REPLY_BUSY);
        send_op(KIND_POLL, 0, 0, 0, 0, 1'b0, REPLY_ACCEPTED);

        run_phase(1024, 4, 110, 1'b0, -1, -1);
        run_phase(1, 3, 90, 1'b0, -1, -1);
        run_phase(0, 3, 40, 1'b0, -1, -1);
        run_phase(16, 0, 40, 1'b0, -1, -1);
        run_phase(2047, 7, 100, 1'b0, -1, -1);
        run_phase(5, 1, 60, 1'b0, -1, -1);
        run_phase(12, 2, 60, 1'b0, -1, -1);
        run_phase(24, 3, 130, 1'b0, 20, -1);
        run_phase(33, 4, 150, 1'b0, -1, 75);
        run_phase(7, 3, 100, 1'b1, -1, -1);
        run_phase(100, 4, 70, 1'b1, -1, -1);

        drain_results();
        repeat (16) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
